// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define LSCU_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LSCU_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/lscu_pkg.sv -----
// Package with operation codes, the decoded request type and queue constants.
`timescale 1ns / 1ps
package lscu_pkg;

   localparam logic [3:0] OP_AND    = 4'd0;
   localparam logic [3:0] OP_OR     = 4'd1;
   localparam logic [3:0] OP_NOR    = 4'd2;
   localparam logic [3:0] OP_XOR    = 4'd3;
   localparam logic [3:0] OP_NAND   = 4'd4;
   localparam logic [3:0] OP_SLL    = 4'd5;
   localparam logic [3:0] OP_SRL    = 4'd6;
   localparam logic [3:0] OP_SRA    = 4'd7;
   localparam logic [3:0] OP_ANDI   = 4'd8;
   localparam logic [3:0] OP_ORI    = 4'd9;
   localparam logic [3:0] OP_NORI   = 4'd10;
   localparam logic [3:0] OP_SLT    = 4'd11;
   localparam logic [3:0] OP_SLTI   = 4'd12;
   localparam logic [3:0] OP_LOAD   = 4'd13;
   localparam logic [3:0] OP_READ   = 4'd14;
   localparam logic [3:0] OP_UNUSED = 4'd15;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // A classified request as it travels from the front end to the execute side.
   typedef struct packed {
      logic [3:0]  op;
      logic [4:0]  rd_a_index;   // src_a, or dest for a read
      logic        a_zero;       // port A reads as zero
      logic [4:0]  src_b;
      logic        b_zero;
      logic [4:0]  dest;
      logic        writes;       // operation produces a register value
      logic        wr_en;        // and the destination accepts it
      logic [4:0]  shamt;
      logic [15:0] imm;
      logic [31:0] load_value;
   } item_type;

endpackage

// ----- rtl/lscu_front.sv -----
// Front end: accepts requests and classifies them for the execute side.
`timescale 1ns / 1ps
module lscu_front
   import lscu_pkg::*;
#(
   parameter int NUM_REGS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_type,
   input  logic [4:0]          req_src_a,
   input  logic [4:0]          req_src_b,
   input  logic [4:0]          req_dest,
   input  logic [4:0]          req_shift_amount,
   input  logic [15:0]         req_immediate,
   input  logic signed [31:0]  req_load_value,
   input  logic                q_full,
   output logic                q_push,
   output item_type            q_item
);

   logic writes;
   logic reads_dest;
   logic dest_ok;
   logic held_ff;
   logic held_in;

   // An index reads as zero when it is register zero or lies past the file.
   function automatic logic index_is_zero(input logic [4:0] idx);
      return (idx == 5'd0) || (32'(idx) >= 32'(NUM_REGS));
   endfunction

   always_comb begin
      unique case (req_type) inside
         [OP_AND:OP_LOAD]: begin
            writes     = 1'b1;
            reads_dest = 1'b0;
         end
         default: begin
            writes     = 1'b0;
            reads_dest = 1'b1;
         end
      endcase
   end

   assign dest_ok   = !index_is_zero(req_dest);
   assign req_ready = !q_full && !held_ff;
   assign q_push    = req_valid && req_ready;

   // Ready stays low in the cycle that reset is released.
   assign held_in = reset;
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   always_comb begin
      q_item.op         = req_type;
      q_item.rd_a_index = reads_dest ? req_dest : req_src_a;
      q_item.a_zero     = index_is_zero(reads_dest ? req_dest : req_src_a);
      q_item.src_b      = req_src_b;
      q_item.b_zero     = index_is_zero(req_src_b);
      q_item.dest       = req_dest;
      q_item.writes     = writes;
      q_item.wr_en      = writes && dest_ok;
      q_item.shamt      = req_shift_amount;
      q_item.imm        = req_immediate;
      q_item.load_value = req_load_value;
   end

endmodule

// ----- rtl/lscu_queue.sv -----
// Short request queue between the front end and the execute side.
`timescale 1ns / 1ps
module lscu_queue
   import lscu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   output logic      full,
   output logic      pop_valid,
   input  logic      pop,
   output item_type  pop_item
);

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/lscu_back.sv -----
// Execute side: register file, operand read, logic/shift/compare and result register.
`timescale 1ns / 1ps
module lscu_back
   import lscu_pkg::*;
#(
   parameter int NUM_REGS   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_result_index,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_wrote_register
);

   localparam int AW = $clog2(NUM_REGS);
   localparam int IW = (AW > 5) ? AW : 5;

   logic [DATA_WIDTH-1:0] mem [NUM_REGS];
   logic [NUM_REGS-1:0]   valid_ff;

   logic [DATA_WIDTH-1:0] rd_a_ff;
   logic [DATA_WIDTH-1:0] rd_b_ff;
   logic                  ex_valid_ff;
   logic                  ex_valid_in;
   item_type              ex_item_ff;
   logic                  ex_adv;

   logic [AW-1:0]         ra;
   logic [AW-1:0]         rb;
   logic [AW-1:0]         waddr;
   logic                  we;
   logic [DATA_WIDTH-1:0] wdata;

   logic [DATA_WIDTH-1:0] op_result;
   logic [DATA_WIDTH-1:0] value;
   logic [DATA_WIDTH-1:0] imm_z;
   logic signed [63:0]    a64;
   logic signed [63:0]    simm64;
   logic signed [63:0]    ld64;
   logic signed [63:0]    val64;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [4:0]            out_index_ff;
   logic [31:0]           out_value_ff;
   logic                  out_wrote_ff;

   function automatic logic [AW-1:0] to_addr(input logic [4:0] idx);
      logic [IW-1:0] wide;
      wide = IW'(idx);
      return wide[AW-1:0];
   endfunction

   assign ex_adv = ex_valid_ff && (!out_valid_ff || rsp_ready);
   assign q_pop  = q_valid && (!ex_valid_ff || ex_adv);

   assign ra    = to_addr(q_item.rd_a_index);
   assign rb    = to_addr(q_item.src_b);
   assign waddr = to_addr(ex_item_ff.dest);
   assign we    = ex_adv && ex_item_ff.wr_en;
   assign wdata = op_result;

   // Register file. The write of the instruction leaving execute is forwarded
   // into the operand read of the one entering it in the same cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (q_pop) begin
         if (q_item.a_zero) begin
            rd_a_ff <= '0;
         end else if (we && waddr == ra) begin
            rd_a_ff <= wdata;
         end else if (!valid_ff[ra]) begin
            rd_a_ff <= '0;
         end else begin
            rd_a_ff <= mem[ra];
         end
         if (q_item.b_zero) begin
            rd_b_ff <= '0;
         end else if (we && waddr == rb) begin
            rd_b_ff <= wdata;
         end else if (!valid_ff[rb]) begin
            rd_b_ff <= '0;
         end else begin
            rd_b_ff <= mem[rb];
         end
      end
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_comb begin
      ex_valid_in = ex_valid_ff;
      if (q_pop) begin
         ex_valid_in = 1'b1;
      end else if (ex_adv) begin
         ex_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff <= ex_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ex_item_ff <= q_item;
      end
   end

   assign imm_z  = DATA_WIDTH'({48'd0, ex_item_ff.imm});
   assign a64    = 64'($signed(rd_a_ff));
   assign simm64 = 64'($signed(ex_item_ff.imm));
   assign ld64   = 64'($signed(ex_item_ff.load_value));

   always_comb begin
      case (ex_item_ff.op)
         OP_AND:  op_result = rd_a_ff & rd_b_ff;
         OP_OR:   op_result = rd_a_ff | rd_b_ff;
         OP_NOR:  op_result = ~(rd_a_ff | rd_b_ff);
         OP_XOR:  op_result = rd_a_ff ^ rd_b_ff;
         OP_NAND: op_result = ~(rd_a_ff & rd_b_ff);
         OP_SLL:  op_result = rd_b_ff << ex_item_ff.shamt;
         OP_SRL:  op_result = rd_b_ff >> ex_item_ff.shamt;
         OP_SRA:  op_result = DATA_WIDTH'($signed(rd_b_ff) >>> ex_item_ff.shamt);
         OP_ANDI: op_result = rd_a_ff & imm_z;
         OP_ORI:  op_result = rd_a_ff | imm_z;
         OP_NORI: op_result = ~(rd_a_ff | imm_z);
         OP_SLT:  op_result = DATA_WIDTH'($signed(rd_a_ff) < $signed(rd_b_ff));
         OP_SLTI: op_result = DATA_WIDTH'(a64 < simm64);
         OP_LOAD: op_result = ld64[DATA_WIDTH-1:0];
         default: op_result = '0;
      endcase
   end

   // A read reports port A, which was pointed at the destination. A write
   // that the destination refuses reports zero.
   always_comb begin
      if (ex_item_ff.wr_en) begin
         value = op_result;
      end else if (ex_item_ff.writes) begin
         value = '0;
      end else begin
         value = rd_a_ff;
      end
      val64 = 64'($signed(value));
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (ex_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_adv) begin
         out_index_ff <= ex_item_ff.dest;
         out_value_ff <= val64[31:0];
         out_wrote_ff <= ex_item_ff.wr_en;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_index   = out_index_ff;
   assign rsp_result_value   = out_value_ff;
   assign rsp_wrote_register = out_wrote_ff;

endmodule

// ----- rtl/logic_shift_compare_unit_top.sv -----
// Top level of the logic, shift and compare execute unit.
// Usage: each request on the req_ channel names an operation (req_type), two
// source registers, a destination, a shift distance, a 16-bit immediate and a
// load value. The unit reads its own register file, computes the operation,
// writes the destination and returns one response on the rsp_ channel with the
// destination index, the value it now holds and whether it was written.
// Both channels use valid and ready; a request moves on a clock edge at
// which both are high.
// An accepted request is first written into the queue; its operands are then
// read into registers, and execute then writes the response register, which
// drives rsp_valid; the response is taken when rsp_ready is high.
// Throughput: one request per cycle while rsp_ready stays high, set by the single
// write port and the two registered read ports of the register file; a write is
// forwarded to a read issued in the same cycle.
// A two-entry queue decouples the front end from the execute side. When the
// receiver holds rsp_ready low, the response register, the execute stage and
// the queue fill in turn, then req_ready drops; nothing is lost.
// Reset (synchronous, active high) clears the queue, the pipeline and the
// per-register written flags, so every register reads zero afterwards;
// req_ready stays low for the first cycle after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module logic_shift_compare_unit_top
   import lscu_pkg::*;
#(
   parameter int NUM_REGS   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_type,
   input  logic [4:0]         req_src_a,
   input  logic [4:0]         req_src_b,
   input  logic [4:0]         req_dest,
   input  logic [4:0]         req_shift_amount,
   input  logic [15:0]        req_immediate,
   input  logic signed [31:0] req_load_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_result_index,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_wrote_register
);

   logic     q_full;
   logic     q_push;
   item_type q_push_item;
   logic     q_valid;
   logic     q_pop;
   item_type q_pop_item;

   // The front end classifies each request and hands it to the queue.
   lscu_front #(
      .NUM_REGS (NUM_REGS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_src_a        (req_src_a),
      .req_src_b        (req_src_b),
      .req_dest         (req_dest),
      .req_shift_amount (req_shift_amount),
      .req_immediate    (req_immediate),
      .req_load_value   (req_load_value),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_push_item)
   );

   lscu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_item  (q_pop_item)
   );

   // The execute side owns the register file and the response register.
   lscu_back #(
      .NUM_REGS   (NUM_REGS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_pop_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_index   (rsp_result_index),
      .rsp_result_value   (rsp_result_value),
      .rsp_wrote_register (rsp_wrote_register)
   );

   // Register zero is never reported as written.
   `LSCU_ASSERT(a_no_write_reg0, rsp_valid && rsp_wrote_register |-> rsp_result_index != 5'd0, "register zero reported as written")

   // Register zero always reports the value zero.
   `LSCU_ASSERT(a_reg0_reads_zero, rsp_valid && rsp_result_index == 5'd0 |-> rsp_result_value == 32'sd0, "register zero reported a nonzero value")

   // No response can be pending in the cycle after reset.
   `LSCU_ASSERT(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid, "response valid right after reset")

   // A request can only enter the queue when it has room.
   `LSCU_ASSERT_ALWAYS(a_push_has_room, q_push |-> !q_full && !reset, "request pushed into a full queue or during reset")

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the logic, shift and compare execute unit.
`timescale 1ns / 1ps
module tb;
   import lscu_pkg::*;

   // The run stops early if this many cycles pass with no handshake on either side.
   localparam int STALL_LIMIT = 1000;
   // Roughly how many requests the run sends in total.
   localparam int TOTAL_ITEMS = 1700;
   // Once fewer requests than this are still waiting, neither side idles any more.
   localparam int CALM_TAIL   = 150;
   // Cycles allowed after the last response for anything unexpected to show up.
   localparam int DRAIN_TAIL  = 10;

   // One request as the sender holds it. Setting the drain bit makes the sender
   // wait for every outstanding response before it offers the request.
   typedef struct packed {
      logic [3:0]  op;
      logic [4:0]  src_a;
      logic [4:0]  src_b;
      logic [4:0]  dest;
      logic [4:0]  shamt;
      logic [15:0] imm;
      logic [31:0] load_value;
      logic        drain;
   } request_type;

   // What one request should put on the response channel.
   typedef struct packed {
      logic [4:0]  index;
      logic [31:0] value;
      logic        wrote;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [3:0]         req_type = OP_READ;
   logic [4:0]         req_src_a = '0;
   logic [4:0]         req_src_b = '0;
   logic [4:0]         req_dest = '0;
   logic [4:0]         req_shift_amount = '0;
   logic [15:0]        req_immediate = '0;
   logic signed [31:0] req_load_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [4:0]         rsp_result_index;
   logic signed [31:0] rsp_result_value;
   logic               rsp_wrote_register;

   request_type pending_q[$];    // requests not yet offered to the unit
   outcome_type expected_q[$];   // responses still owed, oldest first
   request_type on_wire;         // the request the sender is presenting now
   logic [31:0] reg_file [32];   // the testbench's own copy of the register file
   int          failures = 0;
   int          quiet_cycles = 0;
   int          send_gap = 0, send_steady = 0;
   int          recv_gap = 0, recv_steady = 0;

   logic_shift_compare_unit_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_src_a          (req_src_a),
      .req_src_b          (req_src_b),
      .req_dest           (req_dest),
      .req_shift_amount   (req_shift_amount),
      .req_immediate      (req_immediate),
      .req_load_value     (req_load_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_index   (rsp_result_index),
      .rsp_result_value   (rsp_result_value),
      .rsp_wrote_register (rsp_wrote_register)
   );

   always #2 clock = ~clock;

   // Runs one request against the register file copy and returns the response
   // it must produce. Register zero reads as zero and never takes a write.
   // Read, and the unused code 15, leave the file alone and report its contents.
   function automatic outcome_type execute_request(request_type r);
      logic [31:0] a, b, v;
      logic        writes;
      outcome_type o;
      a = (r.src_a == 5'd0) ? 32'd0 : reg_file[r.src_a];
      b = (r.src_b == 5'd0) ? 32'd0 : reg_file[r.src_b];
      v = 32'd0;
      writes = 1'b1;
      case (r.op)
         OP_AND:  v = a & b;
         OP_OR:   v = a | b;
         OP_NOR:  v = ~(a | b);
         OP_XOR:  v = a ^ b;
         OP_NAND: v = ~(a & b);
         OP_SLL:  v = b << r.shamt;
         OP_SRL:  v = b >> r.shamt;
         OP_SRA:  v = $signed(b) >>> r.shamt;
         OP_ANDI: v = a & {16'h0000, r.imm};
         OP_ORI:  v = a | {16'h0000, r.imm};
         OP_NORI: v = ~(a | {16'h0000, r.imm});
         OP_SLT:  v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         OP_SLTI: v = ($signed(a) < $signed({{16{r.imm[15]}}, r.imm})) ? 32'd1 : 32'd0;
         OP_LOAD: v = r.load_value;
         default: writes = 1'b0;
      endcase
      o.wrote = writes && (r.dest != 5'd0);
      if (o.wrote)
         reg_file[r.dest] = v;
      o.index = r.dest;
      o.value = (r.dest == 5'd0) ? 32'd0 : reg_file[r.dest];
      return o;
   endfunction

   function automatic bit tail_phase();
      return pending_q.size() < CALM_TAIL;
   endfunction

   // Decides whether one side idles this cycle. Idling comes in bursts,
   // separated now and then by long stretches with none at all.
   function automatic bit take_gap(inout int gap, inout int steady);
      if (tail_phase())
         return 1'b0;
      if (gap > 0) begin
         gap--;
         return 1'b1;
      end
      if (steady > 0) begin
         steady--;
         return 1'b0;
      end
      case ($urandom_range(9))
         0, 1: begin
            gap = $urandom_range(9);
            return 1'b1;
         end
         2: begin
            steady = $urandom_range(80, 20);
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Values that sit at the edges of signed and unsigned 32-bit arithmetic come up often.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_imm();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic logic [4:0] pick_shift();
      case ($urandom_range(5))
         0: return 5'd0;
         1: return 5'd31;
         default: return 5'($urandom_range(31));
      endcase
   endfunction

   // Queues one request. Every 400th one, early in the random part, waits for
   // the unit to empty completely before it is offered.
   function automatic void push_item(input logic [3:0] op, input logic [4:0] a, b, d, sh,
                                     input logic [15:0] imm, input logic [31:0] ld);
      request_type it;
      it.op = op;
      it.src_a = a;
      it.src_b = b;
      it.dest = d;
      it.shamt = sh;
      it.imm = imm;
      it.load_value = ld;
      it.drain = (pending_q.size() % 400 == 30);
      pending_q.push_back(it);
   endfunction

   // The sender. The expected response is worked out at the edge where a
   // request is accepted, so the register file copy follows the unit's order.
   // A new request is offered only when the channel is free, and valid is
   // given exactly one value per edge.
   always @(posedge clock) begin : drive_requests
      bit hold_off;
      if (reset) begin
         req_valid <= 1'b0;
         foreach (reg_file[i]) reg_file[i] = 32'd0;
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(execute_request(on_wire));
         if (!req_valid || req_ready) begin
            hold_off = pending_q.size() > 0 && pending_q[0].drain && expected_q.size() > 0;
            if (pending_q.size() == 0 || hold_off || take_gap(send_gap, send_steady)) begin
               req_valid <= 1'b0;
            end else begin
               on_wire = pending_q.pop_front();
               req_valid <= 1'b1;
               req_type <= on_wire.op;
               req_src_a <= on_wire.src_a;
               req_src_b <= on_wire.src_b;
               req_dest <= on_wire.dest;
               req_shift_amount <= on_wire.shamt;
               req_immediate <= on_wire.imm;
               req_load_value <= on_wire.load_value;
            end
         end
      end
   end

   // The receiver. Each accepted response is checked field by field against
   // the oldest expectation, and the ready signal stalls in random bursts.
   always @(posedge clock) begin : check_responses
      outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response, index %0d value %h wrote %b", $time,
                        rsp_result_index, rsp_result_value, rsp_wrote_register);
               failures++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_result_index !== want.index) begin
                  $display("%0t: result_index expected %0d, got %0d", $time, want.index,
                           rsp_result_index);
                  failures++;
               end
               if (rsp_result_value !== want.value) begin
                  $display("%0t: result_value of r%0d expected %h, got %h", $time,
                           want.index, want.value, rsp_result_value);
                  failures++;
               end
               if (rsp_wrote_register !== want.wrote) begin
                  $display("%0t: wrote_register of r%0d expected %b, got %b", $time,
                           want.index, want.wrote, rsp_wrote_register);
                  failures++;
               end
            end
         end
         rsp_ready <= !take_gap(recv_gap, recv_steady);
      end
   end

   // Watchdog: counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : run_test
      logic [4:0] work [4];
      logic [3:0] op;
      int         n;

      // Directed part. Registers 1 to 3 and 31 get edge values, a load aimed at
      // register zero must be dropped, and then every operation runs at least once on them.
      push_item(OP_LOAD, 5'd0, 5'd0, 5'd1, 5'd0, 16'h0000, 32'h7FFF_FFFF);
      push_item(OP_LOAD, 5'd0, 5'd0, 5'd2, 5'd0, 16'h0000, 32'h8000_0000);
      push_item(OP_LOAD, 5'd0, 5'd0, 5'd3, 5'd0, 16'h0000, 32'hFFFF_FFFF);
      push_item(OP_LOAD, 5'd0, 5'd0, 5'd0, 5'd0, 16'h0000, 32'hDEAD_BEEF);
      push_item(OP_LOAD, 5'd0, 5'd0, 5'd31, 5'd0, 16'h0000, 32'hA5A5_F00F);
      push_item(OP_AND, 5'd1, 5'd3, 5'd4, 5'd0, 16'h0000, 32'd0);
      push_item(OP_OR, 5'd2, 5'd31, 5'd5, 5'd0, 16'h0000, 32'd0);
      push_item(OP_NOR, 5'd1, 5'd2, 5'd6, 5'd0, 16'h0000, 32'd0);
      push_item(OP_XOR, 5'd3, 5'd31, 5'd7, 5'd0, 16'h0000, 32'd0);
      push_item(OP_NAND, 5'd1, 5'd3, 5'd8, 5'd0, 16'h0000, 32'd0);
      push_item(OP_SLL, 5'd0, 5'd3, 5'd9, 5'd31, 16'h0000, 32'd0);
      push_item(OP_SRL, 5'd0, 5'd3, 5'd10, 5'd31, 16'h0000, 32'd0);
      push_item(OP_SRA, 5'd0, 5'd2, 5'd11, 5'd31, 16'h0000, 32'd0);
      push_item(OP_SRA, 5'd0, 5'd31, 5'd12, 5'd0, 16'h0000, 32'd0);
      push_item(OP_ANDI, 5'd3, 5'd0, 5'd13, 5'd0, 16'hFFFF, 32'd0);
      push_item(OP_ORI, 5'd2, 5'd0, 5'd14, 5'd0, 16'h8000, 32'd0);
      push_item(OP_NORI, 5'd0, 5'd0, 5'd15, 5'd0, 16'h0000, 32'd0);
      push_item(OP_SLT, 5'd2, 5'd1, 5'd16, 5'd0, 16'h0000, 32'd0);
      push_item(OP_SLT, 5'd1, 5'd2, 5'd17, 5'd0, 16'h0000, 32'd0);
      push_item(OP_SLTI, 5'd3, 5'd0, 5'd18, 5'd0, 16'hFFFF, 32'd0);
      push_item(OP_SLTI, 5'd2, 5'd0, 5'd19, 5'd0, 16'h8000, 32'd0);
      push_item(OP_OR, 5'd1, 5'd2, 5'd0, 5'd0, 16'h0000, 32'd0);
      push_item(OP_READ, 5'd0, 5'd0, 5'd0, 5'd0, 16'h0000, 32'd0);
      push_item(OP_UNUSED, 5'd0, 5'd0, 5'd31, 5'd0, 16'h0000, 32'd0);
      push_item(OP_READ, 5'd0, 5'd0, 5'd30, 5'd0, 16'h0000, 32'd0);

      // Random part. Most of it is short programs on a small working set of
      // registers: loads, then dependent operations back to back so that writes
      // are forwarded to the next read, then a read of one of the set. The rest
      // is requests with every field drawn at random.
      while (pending_q.size() < TOTAL_ITEMS) begin
         if ($urandom_range(6) == 0) begin
            push_item(4'($urandom_range(15)), 5'($urandom_range(31)),
                      5'($urandom_range(31)), 5'($urandom_range(31)),
                      5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)), $urandom);
         end else begin
            foreach (work[k]) work[k] = 5'($urandom_range(31));
            n = $urandom_range(3, 1);
            repeat (n)
               push_item(OP_LOAD, 5'($urandom_range(31)), 5'($urandom_range(31)),
                         work[2'($urandom_range(3))], 5'($urandom_range(31)),
                         16'($urandom_range(16'hFFFF)), pick_word());
            n = $urandom_range(6, 2);
            repeat (n) begin
               op = 4'($urandom_range(OP_SLTI, OP_AND));
               push_item(op, work[2'($urandom_range(3))], work[2'($urandom_range(3))],
                         work[2'($urandom_range(3))], pick_shift(), pick_imm(), $urandom);
            end
            op = ($urandom_range(7) == 0) ? OP_UNUSED : OP_READ;
            push_item(op, 5'($urandom_range(31)), 5'($urandom_range(31)),
                      work[2'($urandom_range(3))], 5'($urandom_range(31)),
                      16'($urandom_range(16'hFFFF)), $urandom);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait at falling edges, away from the edge where both sides act, until
      // every request has gone in and every response has come back.
      while (!(pending_q.size() == 0 && !req_valid && expected_q.size() == 0) &&
             quiet_cycles < STALL_LIMIT)
         @(negedge clock);
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding", $time,
                  STALL_LIMIT, expected_q.size());
         $display("CHECKS FAILED");
      end else begin
         // Leave room for a stray response to show up before the verdict.
         repeat (DRAIN_TAIL) @(negedge clock);
         if (failures == 0)
            $display("ALL CHECKS PASSED");
         else
            $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- logic_shift_compare_unit_top.f -----
+incdir+rtl
rtl/lscu_pkg.sv
rtl/lscu_front.sv
rtl/lscu_queue.sv
rtl/lscu_back.sv
rtl/logic_shift_compare_unit_top.sv
verif/tb.sv
